// ===== hdl/light_level_smoother_hysteresis_core_macros.svh =====
// Assertion macros for the light level smoother core.
`ifndef LIGHT_LEVEL_SMOOTHER_HYSTERESIS_CORE_MACROS_SVH
`define LIGHT_LEVEL_SMOOTHER_HYSTERESIS_CORE_MACROS_SVH

// Checked on clk_i, quiet while reset is asserted.
`define LLSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on clk_i, through reset as well.
`define LLSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/llsh_pkg.sv =====
// Shared types and constants of the light level smoother core.
`timescale 1ns / 1ps
package llsh_pkg;

  localparam int LUX_W               = 24;
  localparam int WINDOW_SAMPLES_DEF  = 8;

  localparam logic [LUX_W-1:0] LUX_MAX       = {LUX_W{1'b1}};
  localparam logic [LUX_W-1:0] THRESHOLD_RST = LUX_MAX;
  localparam logic [LUX_W-1:0] HYSTERESIS_RST = LUX_W'(160);

  typedef enum logic {
    REQ_SAMPLE  = 1'b0,
    REQ_RECHECK = 1'b1
  } llsh_req_e;

  typedef enum logic {
    REG_THRESHOLD  = 1'b0,
    REG_HYSTERESIS = 1'b1
  } llsh_reg_e;

  typedef struct packed {
    llsh_req_e        req_type;
    logic [LUX_W-1:0] lux_sample;
  } llsh_in_t;

  typedef struct packed {
    logic [LUX_W-1:0] smoothed_lux;
    logic             inhibit_flag;
  } llsh_out_t;

  // Per-stage pipeline control.
  typedef struct packed {
    logic adv;
    logic vld;
  } llsh_stage_t;

endpackage

// ===== hdl/light_level_smoother_hysteresis_core.sv =====
// Top level of the light level smoother with hysteresis inhibit.
// Takes one beat per clock while the output is not stalled and returns one result
// beat per input beat, in order. The pipeline has four register stages: input,
// window sum, reciprocal product and result. A stall at the output freezes all
// of them. A sample beat shifts the window and updates the average. A recheck
// beat only re-evaluates the inhibit flag against the current average. Register
// writes do not touch the flag until the next beat.
`timescale 1ns / 1ps
`include "light_level_smoother_hysteresis_core_macros.svh"
module light_level_smoother_hysteresis_core import llsh_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  llsh_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output llsh_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  llsh_reg_e        cfg_addr_i,
  input  logic [LUX_W-1:0] cfg_data_i
);

  localparam int SUM_W = LUX_W + $clog2(WINDOW_SAMPLES);

  logic             en;
  logic             va_q, vb_q, vc_q, vd_q;
  llsh_in_t         in_q;
  logic [SUM_W-1:0] sum_w;
  logic [LUX_W-1:0] avg_w;
  logic [LUX_W-1:0] threshold_q;
  logic [LUX_W-1:0] hysteresis_q;
  llsh_stage_t      win_ctl, avg_ctl, flag_ctl;

  assign en          = !vd_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vd_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      hysteresis_q <= HYSTERESIS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_THRESHOLD:  threshold_q  <= cfg_data_i;
        REG_HYSTERESIS: hysteresis_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign win_ctl  = '{adv: en, vld: va_q};
  assign avg_ctl  = '{adv: en, vld: vb_q};
  assign flag_ctl = '{adv: en, vld: vc_q};

  llsh_window #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (win_ctl),
    .item_i (in_q),
    .sum_o  (sum_w)
  );

  llsh_avg #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_avg (
    .clk_i (clk_i),
    .ctl_i (avg_ctl),
    .sum_i (sum_w),
    .avg_o (avg_w)
  );

  llsh_flag u_flag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (flag_ctl),
    .avg_i        (avg_w),
    .threshold_i  (threshold_q),
    .hysteresis_i (hysteresis_q),
    .res_o        (out_data_o)
  );

  `LLSH_ASSERT(a_recheck_keeps_sum, (va_q && en && (in_q.req_type == REQ_RECHECK)) |=> $stable(sum_w), "recheck beat changed window sum")
  `LLSH_ASSERT(a_no_spurious_result, (!va_q && !vb_q && !vc_q && !vd_q && !in_valid_i) |=> !out_valid_o, "result beat without an input beat")
  `LLSH_ASSERT(a_max_threshold_never_sets, (vc_q && en && (threshold_q == LUX_MAX) && !out_data_o.inhibit_flag) |=> !out_data_o.inhibit_flag, "inhibit set above full-scale threshold")

endmodule

// ===== hdl/llsh_window.sv =====
// Sample delay line and running window sum.
`timescale 1ns / 1ps
module llsh_window import llsh_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
  localparam int SUM_W = LUX_W + $clog2(WINDOW_SAMPLES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llsh_stage_t       ctl_i,
  input  llsh_in_t          item_i,
  output logic [SUM_W-1:0]  sum_o
);

  logic [LUX_W-1:0] line_q [WINDOW_SAMPLES];
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  logic             take;

  assign take  = ctl_i.adv && ctl_i.vld && (item_i.req_type == REQ_SAMPLE);
  assign sum_d = sum_q - SUM_W'(line_q[WINDOW_SAMPLES-1]) + SUM_W'(item_i.lux_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_SAMPLES; i++) begin
        line_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (take) begin
      line_q[0] <= item_i.lux_sample;
      for (int i = 1; i < WINDOW_SAMPLES; i++) begin
        line_q[i] <= line_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== hdl/llsh_avg.sv =====
// Window average: sum times a rounded-up reciprocal of the window length.
`timescale 1ns / 1ps
module llsh_avg import llsh_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
  localparam int SUM_W = LUX_W + $clog2(WINDOW_SAMPLES)
) (
  input  logic              clk_i,
  input  llsh_stage_t       ctl_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic [LUX_W-1:0]  avg_o
);

  localparam int SHIFT   = SUM_W + $clog2(WINDOW_SAMPLES);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [SHIFT:0] ONE_K      = {1'b1, {SHIFT{1'b0}}};
  localparam logic [SHIFT:0] RECIP_FULL =
    (ONE_K + (SHIFT+1)'(WINDOW_SAMPLES - 1)) / (SHIFT+1)'(WINDOW_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_FULL[RECIP_W-1:0];

  logic [PROD_W-1:0] prod_q;

  // exact quotient for every sum below 2**SUM_W
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(RECIP);
    end
  end

  assign avg_o = prod_q[SHIFT +: LUX_W];

endmodule

// ===== hdl/llsh_flag.sv =====
// Hysteresis inhibit decision and result register.
`timescale 1ns / 1ps
module llsh_flag import llsh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  llsh_stage_t      ctl_i,
  input  logic [LUX_W-1:0] avg_i,
  input  logic [LUX_W-1:0] threshold_i,
  input  logic [LUX_W-1:0] hysteresis_i,
  output llsh_out_t        res_o
);

  logic             inhibit_q;
  logic             inhibit_d;
  logic [LUX_W-1:0] lux_q;
  logic [LUX_W:0]   low_sum;

  assign low_sum = {1'b0, avg_i} + {1'b0, hysteresis_i};

  always_comb begin
    inhibit_d = inhibit_q;
    if (!inhibit_q && (avg_i > threshold_i)) begin
      inhibit_d = 1'b1;
    end else if (inhibit_q && (low_sum < {1'b0, threshold_i})) begin
      inhibit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inhibit_q <= 1'b0;
    end else if (ctl_i.adv && ctl_i.vld) begin
      inhibit_q <= inhibit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      lux_q <= avg_i;
    end
  end

  assign res_o.smoothed_lux = lux_q;
  assign res_o.inhibit_flag = inhibit_q;

endmodule

// ===== test/tb_light_level_smoother_hysteresis_core.sv =====
// Testbench for the light level smoother core: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module tb_light_level_smoother_hysteresis_core;
  import llsh_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 100;

  class lux_window_scoreboard;
    logic [LUX_W-1:0] ring [WINDOW_SAMPLES_DEF];
    int               wr_pos;
    logic [31:0]      window_total;
    logic [LUX_W-1:0] average;
    logic             inhibit;
    logic [LUX_W-1:0] threshold;
    logic [LUX_W-1:0] hysteresis;
    llsh_out_t        expected_levels [$];
    int               errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos       = 0;
      window_total = '0;
      average      = '0;
      inhibit      = 1'b0;
      threshold    = THRESHOLD_RST;
      hysteresis   = HYSTERESIS_RST;
      errors       = 0;
    endfunction

    function void set_reg(llsh_reg_e addr, logic [LUX_W-1:0] value);
      if (addr == REG_THRESHOLD) begin
        threshold = value;
      end else begin
        hysteresis = value;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Window update on a sample beat, then the inhibit test in its underflow-free form
    function void log_request(llsh_in_t beat);
      llsh_out_t lvl;
      if (beat.req_type == REQ_SAMPLE) begin
        window_total = window_total - 32'(ring[wr_pos]) + 32'(beat.lux_sample);
        ring[wr_pos] = beat.lux_sample;
        wr_pos       = (wr_pos + 1) % WINDOW_SAMPLES_DEF;
        average      = LUX_W'(window_total / WINDOW_SAMPLES_DEF);
      end
      if (!inhibit && average > threshold) begin
        inhibit = 1'b1;
      end else if (inhibit && ({1'b0, average} + {1'b0, hysteresis}) < {1'b0, threshold}) begin
        inhibit = 1'b0;
      end
      lvl.smoothed_lux = average;
      lvl.inhibit_flag = inhibit;
      expected_levels.push_back(lvl);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_level(llsh_out_t got);
      llsh_out_t want;
      if (expected_levels.size() == 0) begin
        report("unexpected result beat", 32'(got), '0);
      end else begin
        want = expected_levels.pop_front();
        if (got.smoothed_lux !== want.smoothed_lux) begin
          report("smoothed_lux", 32'(got.smoothed_lux), 32'(want.smoothed_lux));
        end
        if (got.inhibit_flag !== want.inhibit_flag) begin
          report("inhibit_flag", 32'(got.inhibit_flag), 32'(want.inhibit_flag));
        end
      end
    endtask
  endclass

  logic             clk;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  llsh_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  llsh_out_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  llsh_reg_e        cfg_addr_i;
  logic [LUX_W-1:0] cfg_data_i;

  lux_window_scoreboard sb = new();

  bit               gaps_on = 1'b1;
  int               hold_req = 0;
  int               quiet_cycles = 0;
  logic [LUX_W-1:0] cur_thr = THRESHOLD_RST;
  logic [LUX_W-1:0] cur_hyst = HYSTERESIS_RST;

  light_level_smoother_hysteresis_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_reg(cfg_addr_i, cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        sb.log_request(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_level(out_data_o);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: short random stalls, plus one long hold on request
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        gap_left = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task send_beat(llsh_req_e kind, logic [LUX_W-1:0] lux);
    llsh_in_t beat;
    int       idle;
    beat.req_type   = kind;
    beat.lux_sample = lux;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 3);
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task wait_idle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(llsh_reg_e addr, logic [LUX_W-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task set_levels(logic [LUX_W-1:0] thr, logic [LUX_W-1:0] hyst);
    cur_thr  = thr;
    cur_hyst = hyst;
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_HYSTERESIS, hyst);
    end else begin
      write_reg(REG_HYSTERESIS, hyst);
      write_reg(REG_THRESHOLD, thr);
    end
  endtask

  // Mostly values around the inhibit band so the flag toggles
  function automatic logic [LUX_W-1:0] pick_lux();
    longint centre;
    longint spread;
    longint v;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LUX_MAX;
      2, 3:    return LUX_W'($urandom);
      default: begin
        spread = longint'(cur_hyst) + 64;
        centre = longint'(cur_thr) - longint'(cur_hyst) / 2;
        v = centre - spread + longint'($urandom_range(0, 32'(2 * spread)));
        if (v < 0) v = 0;
        if (v > 64'hFFFFFF) v = 64'hFFFFFF;
        return LUX_W'(v);
      end
    endcase
  endfunction

  initial begin
    logic [LUX_W-1:0] thr;
    logic [LUX_W-1:0] hyst;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i  <= REG_THRESHOLD;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset threshold is full scale and can never be exceeded
    repeat (8) send_beat(REQ_SAMPLE, LUX_MAX);
    send_beat(REQ_RECHECK, 24'h000000);
    send_beat(REQ_SAMPLE, 24'h555555);
    send_beat(REQ_SAMPLE, 24'hAAAAAA);

    // register write alone leaves the flag; the recheck sets it
    wait_idle();
    set_levels('0, LUX_MAX);
    send_beat(REQ_RECHECK, LUX_MAX);

    // average settles exactly on threshold minus band: flag holds, then clears
    wait_idle();
    set_levels(24'h001000, 24'h000100);
    repeat (8) send_beat(REQ_SAMPLE, 24'h000F00);
    send_beat(REQ_SAMPLE, 24'h000E00);
    send_beat(REQ_RECHECK, 24'h123456);
    send_beat(REQ_SAMPLE, LUX_MAX);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      gaps_on = (phase < PHASES - 2);
      case (phase)
        0: begin
          thr  = LUX_MAX;
          hyst = '0;
        end
        1: begin
          thr  = '0;
          hyst = LUX_MAX;
        end
        PHASES - 1: begin
          thr  = LUX_MAX;
          hyst = LUX_MAX;
        end
        default: begin
          thr = LUX_W'($urandom);
          case ($urandom_range(0, 2))
            0:       hyst = '0;
            1:       hyst = LUX_W'($urandom_range(1, 4096));
            default: hyst = LUX_W'($urandom);
          endcase
        end
      endcase
      set_levels(thr, hyst);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (phase == 2 && k == 20) hold_req = 40;
        if (phase == 3 && k == 50) wait_idle();
        if ($urandom_range(0, 6) == 0) begin
          send_beat(REQ_RECHECK, LUX_W'($urandom));
        end else begin
          send_beat(REQ_SAMPLE, pick_lux());
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== light_level_smoother_hysteresis_core.f =====
+incdir+hdl
hdl/llsh_pkg.sv
hdl/llsh_window.sv
hdl/llsh_avg.sv
hdl/llsh_flag.sv
hdl/light_level_smoother_hysteresis_core.sv
test/tb_light_level_smoother_hysteresis_core.sv
